[hdl/bsm_pkg.sv]
// ============================================================================
// Byte stack machine package
// Shared constants, instruction and status codes, and channel payload types.
// ============================================================================
package bsm_pkg;

   // Machine geometry.
   localparam int STACK_DEPTH = 20;
   localparam int NUM_REGS    = 7;
   localparam int SP_REG      = 6;
   localparam int REG_IDX_W   = 3;
   localparam int SLOT_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

   // Stack depth as a 7-bit magnitude, for compares against the pointer.
   localparam logic [6:0] DEPTH_7 = 7'(STACK_DEPTH);

   // Instruction codes.
   localparam logic [3:0] OP_PRINT = 4'd0;
   localparam logic [3:0] OP_INC   = 4'd1;
   localparam logic [3:0] OP_DEC   = 4'd2;
   localparam logic [3:0] OP_PUSH  = 4'd3;
   localparam logic [3:0] OP_POP   = 4'd4;
   localparam logic [3:0] OP_MOV   = 4'd5;
   localparam logic [3:0] OP_LOAD  = 4'd6;
   localparam logic [3:0] OP_ADD   = 4'd7;
   localparam logic [3:0] OP_SUB   = 4'd8;
   localparam logic [3:0] OP_MUL   = 4'd9;

   // Status codes.
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_OVER  = 2'd1;
   localparam logic [1:0] ST_UNDER = 2'd2;
   localparam logic [1:0] ST_ADDR  = 2'd3;

   // Register index that reads as zero and drops writes.
   localparam logic [REG_IDX_W-1:0] REG_NONE = REG_IDX_W'(NUM_REGS);

   // Request payload: one instruction.
   typedef struct packed {
      logic [3:0]           opcode;
      logic [2:0]           dest_reg;
      logic                 src_is_imm;
      logic [2:0]           src_reg;
      logic signed [7:0]    imm_value;
   } req_data_type;

   // Response payload: status and the destination register after the step.
   typedef struct packed {
      logic [1:0]           status;
      logic signed [7:0]    reg_value;
   } rsp_data_type;

endpackage

[hdl/bsm_req_if.sv]
// ============================================================================
// Byte stack machine request channel
// Valid/ready channel that carries one instruction per request.
// ============================================================================
interface bsm_req_if;

   logic                  valid;
   logic                  ready;
   bsm_pkg::req_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

[hdl/bsm_rsp_if.sv]
// ============================================================================
// Byte stack machine response channel
// Valid/ready channel that carries one status and register value per request.
// ============================================================================
interface bsm_rsp_if;

   logic                  valid;
   logic                  ready;
   bsm_pkg::rsp_data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

[hdl/bsm_core.sv]
// ============================================================================
// Byte stack machine execution core
// Holds the register file and the byte stack, and executes one instruction
// per enabled cycle. The result is produced combinationally from the state.
// ============================================================================
module bsm_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  exec_en,
   input  bsm_pkg::req_data_type cmd,
   output bsm_pkg::rsp_data_type result
);

   // Architectural state.
   logic [7:0] regs_ff  [bsm_pkg::NUM_REGS];
   logic [7:0] regs_in  [bsm_pkg::NUM_REGS];
   logic [7:0] stack_ff [bsm_pkg::STACK_DEPTH];
   logic [7:0] stack_in [bsm_pkg::STACK_DEPTH];

   // Operands.
   logic [7:0] op_a;
   logic [7:0] op_b;
   logic [7:0] src_val;
   logic [7:0] sp;
   logic [7:0] mul_lo;
   logic [15:0] mul_full;

   // Single stack read port, shared by pop and load.
   logic [6:0] rd_addr;
   logic [7:0] rd_data;

   // Pointer range checks.
   logic sp_in_range;
   logic sp_empty;
   logic sp_beyond;
   logic ld_in_range;

   // Write controls.
   logic        sp_we;
   logic [7:0]  sp_val;
   logic        dst_we;
   logic [7:0]  dst_val;
   logic        stk_we;
   logic [6:0]  stk_addr;
   logic [7:0]  stk_val;
   logic [1:0]  status;

   // Operand fetch; index seven reads as zero.
   always_comb begin
      op_a    = (cmd.dest_reg == bsm_pkg::REG_NONE) ? 8'd0 : regs_ff[cmd.dest_reg];
      src_val = (cmd.src_reg == bsm_pkg::REG_NONE) ? 8'd0 : regs_ff[cmd.src_reg];
      op_b    = cmd.src_is_imm ? cmd.imm_value : src_val;
      sp      = regs_ff[bsm_pkg::SP_REG];
   end

   // Low byte of the product.
   assign mul_full = op_a * op_b;
   assign mul_lo   = mul_full[7:0];

   // Pointer and address checks on the signed 8-bit values.
   assign sp_in_range = !sp[7] && (sp[6:0] < bsm_pkg::DEPTH_7);
   assign sp_empty    = sp[7] || (sp == 8'd0);
   assign sp_beyond   = !sp[7] && (sp[6:0] > bsm_pkg::DEPTH_7);
   assign ld_in_range = !op_b[7] && (op_b[6:0] < bsm_pkg::DEPTH_7);

   // Stack read: the slot under the pointer for pop, the operand for load.
   always_comb begin
      rd_addr = (cmd.opcode == bsm_pkg::OP_POP) ? (sp[6:0] - 7'd1) : op_b[6:0];
      if (rd_addr < bsm_pkg::DEPTH_7) begin
         rd_data = stack_ff[rd_addr[bsm_pkg::SLOT_W-1:0]];
      end else begin
         rd_data = 8'd0;
      end
   end

   // Instruction decode; a faulting instruction writes nothing.
   always_comb begin
      sp_we    = 1'b0;
      sp_val   = 8'd0;
      dst_we   = 1'b0;
      dst_val  = 8'd0;
      stk_we   = 1'b0;
      stk_addr = 7'd0;
      stk_val  = 8'd0;
      status   = bsm_pkg::ST_OK;
      case (cmd.opcode)
         bsm_pkg::OP_INC: begin
            dst_we  = 1'b1;
            dst_val = op_a + 8'd1;
         end
         bsm_pkg::OP_DEC: begin
            dst_we  = 1'b1;
            dst_val = op_a - 8'd1;
         end
         bsm_pkg::OP_PUSH: begin
            if (sp_in_range) begin
               stk_we   = 1'b1;
               stk_addr = sp[6:0];
               stk_val  = cmd.src_is_imm ? cmd.imm_value : op_a;
               sp_we    = 1'b1;
               sp_val   = sp + 8'd1;
            end else begin
               status = bsm_pkg::ST_OVER;
            end
         end
         bsm_pkg::OP_POP: begin
            if (sp_empty) begin
               status = bsm_pkg::ST_UNDER;
            end else if (sp_beyond) begin
               status = bsm_pkg::ST_OVER;
            end else begin
               // The popped slot is cleared; a pop into the pointer wins over
               // the pointer decrement.
               stk_we   = 1'b1;
               stk_addr = rd_addr;
               stk_val  = 8'd0;
               sp_we    = 1'b1;
               sp_val   = sp - 8'd1;
               dst_we   = 1'b1;
               dst_val  = rd_data;
            end
         end
         bsm_pkg::OP_MOV: begin
            dst_we  = 1'b1;
            dst_val = op_b;
         end
         bsm_pkg::OP_LOAD: begin
            if (ld_in_range) begin
               dst_we  = 1'b1;
               dst_val = rd_data;
            end else begin
               status = bsm_pkg::ST_ADDR;
            end
         end
         bsm_pkg::OP_ADD: begin
            dst_we  = 1'b1;
            dst_val = op_a + op_b;
         end
         bsm_pkg::OP_SUB: begin
            dst_we  = 1'b1;
            dst_val = op_a - op_b;
         end
         bsm_pkg::OP_MUL: begin
            dst_we  = 1'b1;
            dst_val = mul_lo;
         end
         default: begin
            // Print and unused codes leave the state alone.
         end
      endcase
   end

   // Next register file: pointer update first, then the destination.
   always_comb begin
      regs_in = regs_ff;
      if (sp_we) begin
         regs_in[bsm_pkg::SP_REG] = sp_val;
      end
      if (dst_we && (cmd.dest_reg != bsm_pkg::REG_NONE)) begin
         regs_in[cmd.dest_reg] = dst_val;
      end
   end

   // Next stack contents through the single write port.
   always_comb begin
      for (int i = 0; i < bsm_pkg::STACK_DEPTH; i++) begin
         if (stk_we && (stk_addr == 7'(i))) begin
            stack_in[i] = stk_val;
         end else begin
            stack_in[i] = stack_ff[i];
         end
      end
   end

   // State update; reset clears the registers and the stack.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < bsm_pkg::NUM_REGS; i++) begin
            regs_ff[i] <= 8'd0;
         end
         for (int i = 0; i < bsm_pkg::STACK_DEPTH; i++) begin
            stack_ff[i] <= 8'd0;
         end
      end else if (exec_en) begin
         regs_ff  <= regs_in;
         stack_ff <= stack_in;
      end
   end

   // Result: the destination register after the step.
   always_comb begin
      result.status = status;
      if (cmd.dest_reg == bsm_pkg::REG_NONE) begin
         result.reg_value = 8'sd0;
      end else begin
         result.reg_value = regs_in[cmd.dest_reg];
      end
   end

endmodule

[hdl/byte_stack_machine_step_unit.sv]
// ============================================================================
// Byte stack machine step unit
// Executes one byte stack machine instruction per request.
// ============================================================================
//
// Usage:
//   req_chan carries one instruction per request (opcode, registers,
//   immediate). rsp_chan returns one response per request with a status and
//   the value of the destination register after the instruction.
//   A request is registered when it is accepted and executed against the
//   register file and stack once the output register can take its result.
//   Its response is registered in the output register at the end of that
//   cycle. Throughput is one request per cycle while the receiver takes
//   responses: the input register refills in the same cycle its instruction
//   executes, set by the single execute stage in bsm_core.
//   When the receiver stalls, the response holds in the output register; one
//   more request may wait in the input register, after which req_chan.ready
//   drops until the response is taken.
//   Reset is synchronous: all seven registers and every stack slot clear to
//   zero, both pipeline registers empty, and a request can be accepted in
//   the first cycle after reset.
//
module byte_stack_machine_step_unit (
   input logic          clock,
   input logic          reset,
   bsm_req_if.sink      req_chan,
   bsm_rsp_if.source    rsp_chan
);

   // Input register.
   logic                  req_valid_ff;
   logic                  req_valid_in;
   bsm_pkg::req_data_type req_data_ff;
   bsm_pkg::req_data_type req_data_in;

   // Output register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   bsm_pkg::rsp_data_type rsp_data_ff;
   bsm_pkg::rsp_data_type rsp_data_in;
   bsm_pkg::rsp_data_type exec_result;

   logic exec_fire;
   logic req_take;

   // Execute when an instruction waits and the output register can take it.
   assign exec_fire = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || exec_fire;
   assign req_take = req_chan.valid && req_chan.ready;

   bsm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .exec_en (exec_fire),
      .cmd     (req_data_ff),
      .result  (exec_result)
   );

   // Next values of the pipeline registers.
   always_comb begin
      req_valid_in = req_take || (req_valid_ff && !exec_fire);
      req_data_in  = req_take ? req_chan.data : req_data_ff;
      rsp_valid_in = exec_fire || (rsp_valid_ff && !rsp_chan.ready);
      rsp_data_in  = exec_fire ? exec_result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      req_data_ff <= req_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

   // Every executed instruction leaves a response behind.
   a_exec_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      exec_fire |=> rsp_valid_ff)
      else $error("executed request produced no response");

   // Print never faults.
   a_print_ok: assert property (@(posedge clock) disable iff (reset)
      exec_fire && (req_data_ff.opcode == bsm_pkg::OP_PRINT)
      |=> rsp_data_ff.status == bsm_pkg::ST_OK)
      else $error("print returned a fault status");

   // Register arithmetic never faults.
   a_alu_ok: assert property (@(posedge clock) disable iff (reset)
      exec_fire && ((req_data_ff.opcode == bsm_pkg::OP_INC) ||
                    (req_data_ff.opcode == bsm_pkg::OP_DEC) ||
                    (req_data_ff.opcode == bsm_pkg::OP_MOV) ||
                    (req_data_ff.opcode == bsm_pkg::OP_ADD) ||
                    (req_data_ff.opcode == bsm_pkg::OP_SUB) ||
                    (req_data_ff.opcode == bsm_pkg::OP_MUL))
      |=> rsp_data_ff.status == bsm_pkg::ST_OK)
      else $error("register arithmetic returned a fault status");

   // The unmapped register index always reads back as zero.
   a_none_reads_zero: assert property (@(posedge clock) disable iff (reset)
      exec_fire && (req_data_ff.dest_reg == bsm_pkg::REG_NONE)
      |=> rsp_data_ff.reg_value == 8'sd0)
      else $error("unmapped register returned a nonzero value");

endmodule
